### hdl/force_pad_button_detector_defines.svh
// assertion macros shared by the button detector rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef FORCE_PAD_BUTTON_DETECTOR_DEFINES_SVH
`define FORCE_PAD_BUTTON_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define FPB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fpb assertion failed");
`define FPB_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("fpb assertion failed");
`else
`define FPB_ASSERT(lbl, clk, rst_n, prop)
`define FPB_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif

`endif

### hdl/fpb_pkg.sv
// shared types and constants of the button detector
// no dependencies
package fpb_pkg;

  localparam int CHANNELS     = 4;
  localparam int HYSTERESIS   = 2;
  localparam int LANES        = 4;
  localparam int ACTIVE_LANES = (CHANNELS < LANES) ? CHANNELS : LANES;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 8;
  localparam int THR_W    = 8;
  localparam int MASK_W   = LANES;
  localparam int MIX_W    = LEVEL_W + 2;
  localparam int CMP_W    = LEVEL_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = ((LANES * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS   = MASK_W + LANES * LEVEL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [THR_W-1:0]  THR_RESET   = 8'd127;
  localparam logic [MASK_W-1:0] ACTIVE_MASK = MASK_W'((1 << ACTIVE_LANES) - 1);

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_EVAL   = 1'b1
  } req_type_t;

  typedef logic [LEVEL_W-1:0] level_t;

  // per-lane hysteresis decisions toward the merge stage
  typedef struct packed {
    logic [LANES-1:0] set;
    logic [LANES-1:0] clr;
  } fpb_cmp_t;

endpackage

### hdl/fpb_lane.sv
// one force channel: threshold register, iir smoothing filter, hysteresis compare
// depends on fpb_pkg
module fpb_lane
  import fpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                smp_en,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                cfg_en,
  input  logic [THR_W-1:0]    cfg_data,
  output level_t              level,
  output logic                set,
  output logic                clr
);

  level_t            level_r, level_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [LEVEL_W-1:0] fresh;
  logic [MIX_W-1:0]  mixed;
  logic [CMP_W-1:0]  lvl_w, thr_w, hys_w;

  // 255 - (r >> 4) is the complement of the top byte
  assign fresh = ~sample[SAMPLE_W-1 -: LEVEL_W];
  assign mixed = {1'b0, level_r, 1'b0} + {2'b00, level_r} + {2'b00, fresh};

  always_comb begin
    level_nxt = level_r;
    if (smp_en) begin
      level_nxt = mixed[MIX_W-1:2];
    end
  end

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_en) begin
      thr_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      thr_r   <= THR_RESET;
    end else begin
      level_r <= level_nxt;
      thr_r   <= thr_nxt;
    end
  end

  assign lvl_w = {{(CMP_W-LEVEL_W){1'b0}}, level_r};
  assign thr_w = {{(CMP_W-THR_W){1'b0}}, thr_r};
  assign hys_w = CMP_W'(HYSTERESIS);

  // level < thr - hys and level >= thr + hys, rearranged so nothing goes negative
  assign clr   = (lvl_w + hys_w) < thr_w;
  assign set   = lvl_w >= (thr_w + hys_w);
  assign level = level_r;

endmodule

### hdl/fpb_merge.sv
// merges lane decisions into the button mask, detects changes, buffers reports
// depends on fpb_pkg and force_pad_button_detector_defines.svh
`include "force_pad_button_detector_defines.svh"

module fpb_merge
  import fpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  eval_en,
  input  fpb_cmp_t              cmp,
  input  level_t [LANES-1:0]    levels,
  output logic                  buf_full,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [MASK_W-1:0]     last_mask_r, last_mask_nxt;
  logic [MASK_W-1:0]     new_mask;
  logic                  emit;
  logic                  out_fire;
  logic [OUT_DATA_W-1:0] result;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [OUT_DATA_W-1:0] skid_data_r, skid_data_nxt;

  assign new_mask = (last_mask_r & ~cmp.clr) | cmp.set;
  assign emit     = eval_en && (new_mask != last_mask_r);
  assign out_fire = out_valid_r && out_tready;

  always_comb begin
    result = '0;
    result[MASK_W-1:0] = new_mask;
    for (int i = 0; i < LANES; i++) begin
      result[MASK_W + i*LEVEL_W +: LEVEL_W] = levels[i];
    end
  end

  always_comb begin
    last_mask_nxt = last_mask_r;
    if (emit) begin
      last_mask_nxt = new_mask;
    end
  end

  // two-entry output buffer; the second entry catches a report while the first stalls
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mask_r  <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      last_mask_r  <= last_mask_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign buf_full   = skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FPB_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_r || out_valid_r)
  `FPB_ASSERT(a_no_emit_when_full, clk, rst_n, !(emit && skid_valid_r))
  `FPB_ASSERT(a_set_clr_exclusive, clk, rst_n, (cmp.set & cmp.clr) == '0)
  `FPB_ASSERT(a_idle_lanes_clear, clk, rst_n, (last_mask_r & ~ACTIVE_MASK) == '0)
  `FPB_ASSERT_NEXT(a_mask_holds, clk, rst_n, !emit, $stable(last_mask_r))

endmodule

### hdl/force_pad_button_detector.sv
// Force button detector. Takes one item per clock: a sample item (tuser low) updates the
// smoothed level of every channel, an evaluate item (tuser high) runs the hysteresis
// compare of all channels in parallel lanes and reports the mask with the levels when it
// changed. A report appears on out_ in the cycle after its item is accepted if the output
// register is empty or drains at that edge; else it waits in a second register and moves
// to out_ at the edge where the first is taken. The output side holds up to two reports;
// in_tready drops only while both wait. The user must write thresholds via cfg_ only while
// the block is idle, unchecked by the block. Depends on fpb_pkg, fpb_lane, fpb_merge.
module force_pad_button_detector
  import fpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_0 [11:0], sample_1 .. sample_3 above
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pressed [3:0], level_0 .. level_3, zero fill
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [THR_W-1:0]      cfg_wdata
);

  logic               in_acc;
  logic               smp_en;
  logic               eval_en;
  logic               buf_full;
  fpb_cmp_t           cmp;
  level_t [LANES-1:0] levels;

  assign in_tready = !buf_full;
  assign in_acc    = in_tvalid && in_tready;
  assign smp_en    = in_acc && (in_tuser == REQ_SAMPLE);
  assign eval_en   = in_acc && (in_tuser == REQ_EVAL);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < ACTIVE_LANES) begin : g_on
      fpb_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .smp_en   (smp_en),
        .sample   (in_tdata[i*SAMPLE_W +: SAMPLE_W]),
        .cfg_en   (cfg_we && (cfg_addr == CFG_IDX_W'(i))),
        .cfg_data (cfg_wdata),
        .level    (levels[i]),
        .set      (cmp.set[i]),
        .clr      (cmp.clr[i])
      );
    end else begin : g_off
      // unused channel: level stays zero and its button never changes
      assign levels[i]  = '0;
      assign cmp.set[i] = 1'b0;
      assign cmp.clr[i] = 1'b0;
    end
  end

  fpb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .eval_en    (eval_en),
    .cmp        (cmp),
    .levels     (levels),
    .buf_full   (buf_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
